@@ hdl/pctsb_pkg.sv @@
package pctsb_pkg;

   // field widths
   localparam int COORD_BITS    = 16;
   localparam int IDX_BITS      = 10;
   localparam int RANGE_BITS    = 16;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int COUNT_BITS    = 11;

   // iteration counts and internal widths
   localparam int STEP_BITS    = 5;
   localparam int CORDIC_STEPS = 18;
   localparam int SQRT_STEPS   = 16;
   localparam int DIV_STEPS    = 20;
   localparam int SQ_BITS      = 32;
   localparam int CX_BITS      = 28;
   localparam int ACC_BITS     = 22;
   localparam int BEAR_BITS    = 18;
   localparam int DIFF_BITS    = 19;
   localparam int NUM_BITS     = 20;
   localparam int DEN_BITS     = 17;

   localparam logic signed [ACC_BITS-1:0] HALF_TURN = 22'sd524288;
   localparam logic signed [ACC_BITS-1:0] FULL_TURN = 22'sd1048576;

   // item modes
   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_ADD   = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;
   localparam logic [1:0] MODE_NONE  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_STATIC_HEIGHT = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SENSOR_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ANGLE_MIN     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ANGLE_STEP    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BIN_COUNT     = 3'd4;

   typedef struct packed {
      logic [1:0]                   mode;
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] point_z;
      logic [IDX_BITS-1:0]          read_index;
   } req_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]   bin_index;
      logic [RANGE_BITS-1:0] range_mm;
      logic                  has_return;
      logic                  out_of_span;
   } rsp_type;

   typedef struct packed {
      logic                 load_req;
      logic                 sq_x;
      logic                 sq_y;
      logic                 iter;
      logic                 fin;
      logic                 prep;
      logic                 div;
      logic                 wr;
      logic                 rd;
      logic                 rd_cap;
      logic                 clr_wr;
      logic                 res_zero;
      logic                 out_load;
      logic [STEP_BITS-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       pass_cut;
   } status_type;

   // atan(2^-i) in units of 2^-20 turn
   function automatic logic signed [ACC_BITS-1:0] atan_val(input logic [STEP_BITS-1:0] i);
      logic signed [ACC_BITS-1:0] v;
      unique case (i)
         5'd0:    v = 22'sd131072;
         5'd1:    v = 22'sd77376;
         5'd2:    v = 22'sd40884;
         5'd3:    v = 22'sd20753;
         5'd4:    v = 22'sd10417;
         5'd5:    v = 22'sd5213;
         5'd6:    v = 22'sd2607;
         5'd7:    v = 22'sd1304;
         5'd8:    v = 22'sd652;
         5'd9:    v = 22'sd326;
         5'd10:   v = 22'sd163;
         5'd11:   v = 22'sd81;
         5'd12:   v = 22'sd41;
         5'd13:   v = 22'sd20;
         5'd14:   v = 22'sd10;
         5'd15:   v = 22'sd5;
         5'd16:   v = 22'sd3;
         5'd17:   v = 22'sd1;
         default: v = 22'sd0;
      endcase
      return v;
   endfunction

endpackage

@@ hdl/pctsb_ctrl.sv @@
module pctsb_ctrl #(
   parameter int MAX_BINS = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  pctsb_pkg::status_type        status,
   output pctsb_pkg::cmd_type           cmd,
   output logic [$clog2(MAX_BINS)-1:0]  clr_addr
);

   localparam int AW = $clog2(MAX_BINS);
   localparam int SB = pctsb_pkg::STEP_BITS;
   localparam int CW = (AW > SB) ? AW : SB;

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_EVAL   = 13'b0000000000010,
      ST_SQX    = 13'b0000000000100,
      ST_SQY    = 13'b0000000001000,
      ST_ITER   = 13'b0000000010000,
      ST_FIN    = 13'b0000000100000,
      ST_PREP   = 13'b0000001000000,
      ST_DIV    = 13'b0000010000000,
      ST_WRITE  = 13'b0000100000000,
      ST_READ   = 13'b0001000000000,
      ST_RDWAIT = 13'b0010000000000,
      ST_CLEAR  = 13'b0100000000000,
      ST_DONE   = 13'b1000000000000
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            clr_item_ff, clr_item_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            clr_last, iter_last, div_last;

   assign clr_last  = (cnt_ff[AW-1:0] == AW'(MAX_BINS - 1));
   assign iter_last = (cnt_ff[SB-1:0] == SB'(pctsb_pkg::CORDIC_STEPS - 1));
   assign div_last  = (cnt_ff[SB-1:0] == SB'(pctsb_pkg::DIV_STEPS - 1));

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign clr_addr  = cnt_ff[AW-1:0];

   // sequence one transaction
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      clr_item_in = clr_item_ff;
      cmd         = '0;
      cmd.step    = cnt_ff[SB-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cnt_in = '0;
            unique case (status.mode)
               pctsb_pkg::MODE_CLEAR: begin
                  cmd.res_zero = 1'b1;
                  clr_item_in  = 1'b1;
                  state_in     = ST_CLEAR;
               end
               pctsb_pkg::MODE_ADD: begin
                  if (status.pass_cut) begin
                     state_in = ST_SQX;
                  end else begin
                     cmd.res_zero = 1'b1;
                     state_in     = ST_DONE;
                  end
               end
               pctsb_pkg::MODE_READ: begin
                  state_in = ST_READ;
               end
               default: begin
                  cmd.res_zero = 1'b1;
                  state_in     = ST_DONE;
               end
            endcase
         end
         ST_SQX: begin
            cmd.sq_x = 1'b1;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            cmd.sq_y = 1'b1;
            cnt_in   = '0;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            cmd.iter = 1'b1;
            if (iter_last) begin
               state_in = ST_FIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FIN: begin
            cmd.fin  = 1'b1;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            if (div_last) begin
               state_in = ST_WRITE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_WRITE: begin
            cmd.wr   = 1'b1;
            state_in = ST_DONE;
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_RDWAIT;
         end
         ST_RDWAIT: begin
            cmd.rd_cap = 1'b1;
            state_in   = ST_DONE;
         end
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (clr_last) begin
               state_in    = clr_item_ff ? ST_DONE : ST_IDLE;
               clr_item_in = 1'b0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold the result valid until taken
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         clr_item_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         clr_item_ff  <= clr_item_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hdl/pctsb_dpath.sv @@
module pctsb_dpath #(
   parameter int MAX_BINS = 1024
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write,
   input  logic [pctsb_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [pctsb_pkg::CSR_DATA_BITS-1:0]      csr_data,
   input  pctsb_pkg::req_type                       req_data,
   output pctsb_pkg::rsp_type                       rsp_data,
   input  pctsb_pkg::cmd_type                       cmd,
   input  logic [$clog2(MAX_BINS)-1:0]              clr_addr,
   output pctsb_pkg::status_type                    status
);

   localparam int AW = $clog2(MAX_BINS);
   localparam int IB = pctsb_pkg::IDX_BITS;
   localparam int LW = (((AW + 1) > IB) ? (AW + 1) : IB) + 1;
   localparam int RB = pctsb_pkg::RANGE_BITS;
   localparam int CB = pctsb_pkg::COORD_BITS;
   localparam int XB = pctsb_pkg::CX_BITS;
   localparam int AB = pctsb_pkg::ACC_BITS;
   localparam int BB = pctsb_pkg::BEAR_BITS;
   localparam int DB = pctsb_pkg::DIFF_BITS;
   localparam int NB = pctsb_pkg::NUM_BITS;
   localparam int EB = pctsb_pkg::DEN_BITS;
   localparam int QB = pctsb_pkg::SQ_BITS;

   // configuration registers
   logic signed [15:0]                    sh_ff, sn_ff, amin_ff;
   logic [15:0]                           astep_ff;
   logic [pctsb_pkg::COUNT_BITS-1:0]      bcnt_ff;

   pctsb_pkg::req_type                    req_ff;
   logic [QB-1:0]                         sq_ff, rem_ff, root_ff;
   logic signed [XB-1:0]                  x_ff, y_ff;
   logic signed [AB-1:0]                  acc_ff;
   logic                                  zero_ff;
   logic [RB-1:0]                         range_ff;
   logic signed [BB-1:0]                  bear_ff;
   logic                                  dneg_ff;
   logic [NB-1:0]                         quo_ff;
   logic [EB-1:0]                         den_ff;
   logic [EB:0]                           remd_ff;
   logic [RB:0]                           rd_ff;
   logic                                  rd_ok_ff;
   pctsb_pkg::rsp_type                    res_ff, rsp_ff;
   logic [RB:0]                           mem [MAX_BINS];

   always_ff @(posedge clock) begin
      if (reset) begin
         sh_ff    <= 16'sd300;
         sn_ff    <= 16'sd0;
         amin_ff  <= -16'sd32768;
         astep_ff <= 16'd91;
         bcnt_ff  <= 11'd720;
      end else if (csr_write) begin
         unique case (csr_index)
            pctsb_pkg::CSR_STATIC_HEIGHT: sh_ff    <= csr_data;
            pctsb_pkg::CSR_SENSOR_HEIGHT: sn_ff    <= csr_data;
            pctsb_pkg::CSR_ANGLE_MIN:     amin_ff  <= csr_data;
            pctsb_pkg::CSR_ANGLE_STEP:    astep_ff <= csr_data;
            pctsb_pkg::CSR_BIN_COUNT:     bcnt_ff  <= csr_data[pctsb_pkg::COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // height test
   logic signed [16:0] cut_w, pz_w;
   assign cut_w = {sh_ff[15], sh_ff} - {sn_ff[15], sn_ff};
   assign pz_w  = 17'(req_ff.point_z);
   assign status.mode     = req_ff.mode;
   assign status.pass_cut = (pz_w >= cut_w);

   // magnitudes and CORDIC start values
   logic [CB-1:0]        ax_w, ay_w;
   logic [QB-1:0]        sqx_w, sqy_w;
   logic signed [XB-1:0] px_w, py_w;
   logic                 neg_w;
   assign ax_w  = req_ff.point_x[CB-1] ? CB'(~req_ff.point_x + 1'b1) : req_ff.point_x;
   assign ay_w  = req_ff.point_y[CB-1] ? CB'(~req_ff.point_y + 1'b1) : req_ff.point_y;
   assign sqx_w = QB'(ax_w) * QB'(ax_w);
   assign sqy_w = QB'(ay_w) * QB'(ay_w);
   assign px_w  = XB'(req_ff.point_x);
   assign py_w  = XB'(req_ff.point_y);
   assign neg_w = req_ff.point_x[CB-1];

   // one CORDIC step and one square-root digit
   logic signed [XB-1:0] dx_w, dy_w;
   logic [QB-1:0]        bit_w, trial_w;
   assign dx_w    = y_ff >>> cmd.step;
   assign dy_w    = x_ff >>> cmd.step;
   assign bit_w   = 32'h4000_0000 >> {cmd.step, 1'b0};
   assign trial_w = root_ff + bit_w;

   // bearing wrap and rounding
   logic signed [AB-1:0] accw_w, accr_w;
   assign accw_w = (acc_ff > pctsb_pkg::HALF_TURN) ? (acc_ff - pctsb_pkg::FULL_TURN) : acc_ff;
   assign accr_w = accw_w + AB'(8);

   // bin offset and rounded-quotient operands
   logic signed [DB-1:0] diff_w;
   logic [DB-1:0]        adiff_w;
   assign diff_w  = DB'(bear_ff) - DB'(amin_ff);
   assign adiff_w = diff_w[DB-1] ? DB'(~diff_w + 1'b1) : diff_w;

   // restoring divider step
   logic [EB:0] dt_w;
   assign dt_w = {remd_ff[EB-1:0], quo_ff[NB-1]};

   // span check
   logic [LW-1:0] lim_w;
   logic          span_w;
   assign lim_w  = (LW'(bcnt_ff) < LW'(MAX_BINS)) ? LW'(bcnt_ff) : LW'(MAX_BINS);
   assign span_w = (astep_ff != 16'd0) && (!dneg_ff || (quo_ff == '0))
                   && (NB'(lim_w) > quo_ff);

   // read address
   logic [LW-1:0] ridx_w;
   assign ridx_w = LW'(req_ff.read_index);

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.sq_x) begin
         sq_ff   <= sqx_w;
         zero_ff <= (req_ff.point_x == '0) && (req_ff.point_y == '0);
         x_ff    <= (neg_w ? -px_w : px_w) <<< 8;
         y_ff    <= (neg_w ? -py_w : py_w) <<< 8;
         acc_ff  <= neg_w ? pctsb_pkg::HALF_TURN : '0;
      end
      if (cmd.sq_y) begin
         rem_ff  <= sq_ff + sqy_w;
         root_ff <= '0;
      end
      if (cmd.iter) begin
         if (y_ff > 0) begin
            x_ff   <= x_ff + dx_w;
            y_ff   <= y_ff - dy_w;
            acc_ff <= acc_ff + pctsb_pkg::atan_val(cmd.step);
         end else begin
            x_ff   <= x_ff - dx_w;
            y_ff   <= y_ff + dy_w;
            acc_ff <= acc_ff - pctsb_pkg::atan_val(cmd.step);
         end
         if (cmd.step < pctsb_pkg::STEP_BITS'(pctsb_pkg::SQRT_STEPS)) begin
            if (rem_ff >= trial_w) begin
               rem_ff  <= rem_ff - trial_w;
               root_ff <= (root_ff >> 1) + bit_w;
            end else begin
               root_ff <= root_ff >> 1;
            end
         end
      end
      if (cmd.fin) begin
         range_ff <= RB'(root_ff + QB'(rem_ff > root_ff));
         bear_ff  <= zero_ff ? '0 : accr_w[AB-1:4];
      end
      if (cmd.prep) begin
         dneg_ff <= diff_w[DB-1];
         quo_ff  <= NB'({adiff_w, 1'b0}) + NB'(astep_ff);
         den_ff  <= {astep_ff, 1'b0};
         remd_ff <= '0;
      end
      if (cmd.div) begin
         if (dt_w >= {1'b0, den_ff}) begin
            remd_ff <= dt_w - {1'b0, den_ff};
            quo_ff  <= {quo_ff[NB-2:0], 1'b1};
         end else begin
            remd_ff <= dt_w;
            quo_ff  <= {quo_ff[NB-2:0], 1'b0};
         end
      end
      // result of the current transaction
      if (cmd.res_zero) begin
         res_ff <= '0;
      end else if (cmd.wr) begin
         res_ff.bin_index   <= span_w ? quo_ff[IB-1:0] : '0;
         res_ff.range_mm    <= range_ff;
         res_ff.has_return  <= span_w;
         res_ff.out_of_span <= !span_w;
      end else if (cmd.rd_cap) begin
         res_ff.bin_index   <= req_ff.read_index;
         res_ff.range_mm    <= (rd_ok_ff && rd_ff[RB]) ? rd_ff[RB-1:0] : '0;
         res_ff.has_return  <= rd_ok_ff && rd_ff[RB];
         res_ff.out_of_span <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_ff <= res_ff;
      end
   end

   // bin store: valid flag over range
   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         mem[clr_addr] <= '0;
      end else if (cmd.wr && span_w) begin
         mem[quo_ff[AW-1:0]] <= {1'b1, range_ff};
      end
      if (cmd.rd) begin
         rd_ff    <= mem[ridx_w[AW-1:0]];
         rd_ok_ff <= (ridx_w < LW'(MAX_BINS));
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ hdl/point_cloud_to_scan_binning_top.sv @@
// channel   direction  handshake                  payload
// req_      in         req_valid / req_stall      req_data  (pctsb_pkg::req_type)
// rsp_      out        rsp_valid / rsp_stall      rsp_data  (pctsb_pkg::rsp_type)
// csr_      in         csr_write                  csr_index, csr_data
//
// Add point: runs the 18 CORDIC steps
// (square root runs beside them) and the 20-step restoring divider for the bin.
// Below-cut point, unused mode: all-zero result. Read bin: registered store read.
// Clear: all MAX_BINS store entries, one store entry per cycle.
// After reset the same clearing pass runs before req_stall drops.
// One transaction at a time; a finished result waits in the output register,
// and the next one is accepted while it waits.
module point_cloud_to_scan_binning_top #(
   parameter int MAX_BINS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  pctsb_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output pctsb_pkg::rsp_type                  rsp_data,
   input  logic                                csr_write,
   input  logic [pctsb_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [pctsb_pkg::CSR_DATA_BITS-1:0] csr_data
);

   pctsb_pkg::cmd_type             cmd;
   pctsb_pkg::status_type          status;
   logic [$clog2(MAX_BINS)-1:0]    clr_addr;

   pctsb_ctrl #(
      .MAX_BINS (MAX_BINS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd),
      .clr_addr  (clr_addr)
   );

   pctsb_dpath #(
      .MAX_BINS (MAX_BINS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .clr_addr  (clr_addr),
      .status    (status)
   );

   // go busy after every accepted transaction
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block did not go busy after accepting a transaction");

   // load the output register only when it is free or being drained
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || !rsp_stall))
      else $error("result overwritten while still pending");

   // a new result appears only through an output load
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.out_load))
      else $error("result valid raised without an output load");

endmodule
